// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int BDQ_DEPTH = 16;
    localparam int KIND_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_DUMP_FWD   = 3'd4,
        KIND_DUMP_BWD   = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
        t_status                    status;
        logic                       last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/bounded_double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Double-ended queue of signed 32-bit values in a ring store of DEPTH entries.
//
//   Channel   Direction  Handshake               Fields
//   command   in         i_start and not o_busy  i_kind, i_value
//   result    out        o_valid strobe          o_item_value, o_status, o_last
//
// A push, a rejected operation or an empty dump leaves the unit idle; its beat
// appears the cycle after acceptance and the next command is taken at once.
// A pop holds o_busy through ST_POP while the store's registered read returns.
// A dump of N entries holds o_busy through ST_DUMP and streams one beat per cycle.
// The synchronous reset empties the queue; the store itself is not cleared.
// The receiver cannot stall, so o_busy depends only on the operation in work.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue_unit #(
    parameter int DEPTH = bdq_pkg::BDQ_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [bdq_pkg::KIND_W-1:0]          i_kind,
    input  wire logic signed [bdq_pkg::VALUE_W-1:0]  i_value,
    output logic                                     o_valid,
    output logic signed [bdq_pkg::VALUE_W-1:0]       o_item_value,
    output logic [bdq_pkg::STATUS_W-1:0]             o_status,
    output logic                                     o_last
);
    import bdq_pkg::*;
`include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);

    t_ram_ctl                  ram_ctl;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    t_result                   result;
    logic                      push_accept;

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_item_value;
    t_status                   r_status;
    logic                      r_last;

    bdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_kind    (i_kind),
        .i_value   (i_value),
        .o_busy    (o_busy),
        .o_ram_ctl (ram_ctl),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_result  (result)
    );

    bdq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item_value <= result.value;
        r_status     <= result.status;
        r_last       <= result.last;
    end

    assign o_valid      = r_valid;
    assign o_item_value = r_item_value;
    assign o_status     = r_status;
    assign o_last       = r_last;

    assign push_accept = i_start && !o_busy &&
                         (i_kind == KIND_PUSH_FRONT || i_kind == KIND_PUSH_BACK);

    `ASSERT_NEXT(a_push_beat, i_clk, i_rst_n, push_accept, o_valid && o_last)
    `ASSERT_SAME(a_error_is_last, i_clk, i_rst_n, o_valid && o_status != STATUS_OK, o_last)
    `ASSERT_NEXT(a_dump_contiguous, i_clk, i_rst_n, o_valid && !o_last, o_valid)

endmodule

`default_nettype wire

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
    parameter int DEPTH = bdq_pkg::BDQ_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                                i_clk,
    input  wire bdq_pkg::t_ram_ctl                   i_ctl,
    input  wire logic [AW-1:0]                       i_wr_addr,
    input  wire logic signed [bdq_pkg::VALUE_W-1:0]  i_wr_data,
    input  wire logic [AW-1:0]                       i_rd_addr,
    output logic signed [bdq_pkg::VALUE_W-1:0]       o_rd_data
);
    import bdq_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Pointer and count keeping, operation decode and the dump sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl #(
    parameter int DEPTH = bdq_pkg::BDQ_DEPTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [bdq_pkg::KIND_W-1:0]          i_kind,
    input  wire logic signed [bdq_pkg::VALUE_W-1:0]  i_value,
    output logic                                     o_busy,
    output bdq_pkg::t_ram_ctl                        o_ram_ctl,
    output logic [AW-1:0]                            o_wr_addr,
    output logic signed [bdq_pkg::VALUE_W-1:0]       o_wr_data,
    output logic [AW-1:0]                            o_rd_addr,
    input  wire logic signed [bdq_pkg::VALUE_W-1:0]  i_rd_data,
    output bdq_pkg::t_result                         o_result
);
    import bdq_pkg::*;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [AW-1:0]   r_back,  n_back;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx,   n_idx;
    logic [CW-1:0]   r_left,  n_left;
    logic            r_bwd,   n_bwd;

    logic            full;
    logic            empty;
    logic [AW-1:0]   front_prev;
    logic [AW-1:0]   back_prev;
    logic [AW-1:0]   idx_step;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign front_prev = ring_prev(r_front);
    assign back_prev  = ring_prev(r_back);
    assign idx_step   = r_bwd ? ring_prev(r_idx) : ring_next(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_left  <= '0;
            r_bwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_bwd   <= n_bwd;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_idx     = r_idx;
        n_left    = r_left;
        n_bwd     = r_bwd;
        o_ram_ctl = '0;
        o_wr_addr = r_back;
        o_wr_data = i_value;
        o_rd_addr = r_front;
        o_result  = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                            o_result.valid = 1'b1;
                            o_result.last  = 1'b1;
                            if (full) begin
                                o_result.status = STATUS_FULL;
                            end else begin
                                o_result.status  = STATUS_OK;
                                o_ram_ctl.wr_en  = 1'b1;
                                n_count          = r_count + CW'(1);
                                if (i_kind == KIND_PUSH_FRONT) begin
                                    o_wr_addr = front_prev;
                                    n_front   = front_prev;
                                end else begin
                                    o_wr_addr = r_back;
                                    n_back    = ring_next(r_back);
                                end
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK: begin
                            if (empty) begin
                                o_result.valid  = 1'b1;
                                o_result.status = STATUS_EMPTY;
                                o_result.last   = 1'b1;
                            end else begin
                                o_ram_ctl.rd_en = 1'b1;
                                n_count         = r_count - CW'(1);
                                n_state         = ST_POP;
                                if (i_kind == KIND_POP_FRONT) begin
                                    o_rd_addr = r_front;
                                    n_front   = ring_next(r_front);
                                end else begin
                                    o_rd_addr = back_prev;
                                    n_back    = back_prev;
                                end
                            end
                        end
                        KIND_DUMP_FWD, KIND_DUMP_BWD: begin
                            if (empty) begin
                                o_result.valid  = 1'b1;
                                o_result.status = STATUS_EMPTY;
                                o_result.last   = 1'b1;
                            end else begin
                                o_ram_ctl.rd_en = 1'b1;
                                o_rd_addr       = (i_kind == KIND_DUMP_BWD) ? back_prev
                                                                            : r_front;
                                n_idx           = o_rd_addr;
                                n_left          = r_count;
                                n_bwd           = (i_kind == KIND_DUMP_BWD);
                                n_state         = ST_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                o_result.valid  = 1'b1;
                o_result.value  = i_rd_data;
                o_result.status = STATUS_OK;
                o_result.last   = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_DUMP: begin
                o_result.valid  = 1'b1;
                o_result.value  = i_rd_data;
                o_result.status = STATUS_OK;
                o_result.last   = (r_left == CW'(1));
                if (r_left == CW'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    o_ram_ctl.rd_en = 1'b1;
                    o_rd_addr       = idx_step;
                    n_idx           = idx_step;
                    n_left          = r_left - CW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: sim/bounded_double_ended_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit_tb
// Self-checking testbench for the bounded double-ended queue. A short table
// of directed operations covers empty, full, extreme and ignored cases. It is
// followed by random fill and drain sequences with random dumps, under three
// levels of sender idling. Every result beat is checked field by field
// against the table entry or an in-order model of the ring store.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_OPS   = 145;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        t_status                   status;
        logic                      last;
    } beat_t;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        int                        reps;
        bit                        typed;
        logic signed [VALUE_W-1:0] exp_value;
        t_status                   exp_status;
    } dir_row_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_start;
    logic                       o_busy;
    logic [KIND_W-1:0]          i_kind;
    logic signed [VALUE_W-1:0]  i_value;
    logic                       o_valid;
    logic signed [VALUE_W-1:0]  o_item_value;
    logic [STATUS_W-1:0]        o_status;
    logic                       o_last;

    beat_t expected_beats[$];
    beat_t step_beats[$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    idle_pct    = 0;

    logic signed [VALUE_W-1:0] ring_model [BDQ_DEPTH];
    int unsigned               head_idx = 0;
    int unsigned               tail_idx = 0;
    int unsigned               fill     = 0;

    localparam int DIR_ROWS = 21;
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{KIND_POP_FRONT,  32'sd0,           1,  1'b1, 32'sd0,  STATUS_EMPTY},
        '{KIND_POP_BACK,   32'sd0,           1,  1'b1, 32'sd0,  STATUS_EMPTY},
        '{KIND_DUMP_FWD,   32'sd0,           1,  1'b1, 32'sd0,  STATUS_EMPTY},
        '{KIND_DUMP_BWD,   32'sd0,           1,  1'b1, 32'sd0,  STATUS_EMPTY},
        '{KIND_UNUSED_6,   32'sd0,           1,  1'b0, 32'sd0,  STATUS_OK},
        '{KIND_UNUSED_7,   -32'sd1,          1,  1'b0, 32'sd0,  STATUS_OK},
        '{KIND_PUSH_BACK,  32'h7fff_ffff,    1,  1'b1, 32'sd0,  STATUS_OK},
        '{KIND_PUSH_FRONT, 32'h8000_0000,    1,  1'b1, 32'sd0,  STATUS_OK},
        '{KIND_PUSH_BACK,  32'sd0,           1,  1'b1, 32'sd0,  STATUS_OK},
        '{KIND_PUSH_FRONT, -32'sd1,          1,  1'b1, 32'sd0,  STATUS_OK},
        '{KIND_DUMP_FWD,   32'sd0,           1,  1'b0, 32'sd0,  STATUS_OK},
        '{KIND_DUMP_BWD,   32'sd0,           1,  1'b0, 32'sd0,  STATUS_OK},
        '{KIND_POP_FRONT,  32'sd0,           1,  1'b1, -32'sd1, STATUS_OK},
        '{KIND_POP_BACK,   32'sd0,           1,  1'b1, 32'sd0,  STATUS_OK},
        '{KIND_PUSH_BACK,  32'h1234_0000,    14, 1'b1, 32'sd0,  STATUS_OK},
        '{KIND_PUSH_FRONT, 32'h0bad_f00d,    1,  1'b1, 32'sd0,  STATUS_FULL},
        '{KIND_PUSH_BACK,  32'h0bad_f00d,    1,  1'b1, 32'sd0,  STATUS_FULL},
        '{KIND_DUMP_FWD,   32'sd0,           1,  1'b0, 32'sd0,  STATUS_OK},
        '{KIND_DUMP_BWD,   32'sd0,           1,  1'b0, 32'sd0,  STATUS_OK},
        '{KIND_POP_BACK,   32'sd0,           2,  1'b0, 32'sd0,  STATUS_OK},
        '{KIND_POP_FRONT,  32'sd0,           1,  1'b0, 32'sd0,  STATUS_OK}
    };

    bounded_double_ended_queue_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_item_value (o_item_value),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_next(int unsigned i);
        return (i + 1) % BDQ_DEPTH;
    endfunction

    function automatic int unsigned ring_prev(int unsigned i);
        return (i + BDQ_DEPTH - 1) % BDQ_DEPTH;
    endfunction

    function automatic beat_t make_beat(logic signed [VALUE_W-1:0] value, t_status status,
                                        logic last);
        beat_t b;
        b.value  = value;
        b.status = status;
        b.last   = last;
        return b;
    endfunction

    task automatic run_queue_op(input logic [KIND_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] value);
        int unsigned idx;
        step_beats.delete();
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (fill >= BDQ_DEPTH) begin
                    step_beats.push_back(make_beat('0, STATUS_FULL, 1'b1));
                end else begin
                    if (kind == KIND_PUSH_FRONT) begin
                        head_idx = ring_prev(head_idx);
                        ring_model[head_idx] = value;
                    end else begin
                        ring_model[tail_idx] = value;
                        tail_idx = ring_next(tail_idx);
                    end
                    fill++;
                    step_beats.push_back(make_beat('0, STATUS_OK, 1'b1));
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (fill == 0) begin
                    step_beats.push_back(make_beat('0, STATUS_EMPTY, 1'b1));
                end else begin
                    if (kind == KIND_POP_FRONT) begin
                        idx = head_idx;
                        head_idx = ring_next(head_idx);
                    end else begin
                        tail_idx = ring_prev(tail_idx);
                        idx = tail_idx;
                    end
                    fill--;
                    step_beats.push_back(make_beat(ring_model[idx], STATUS_OK, 1'b1));
                end
            end
            KIND_DUMP_FWD, KIND_DUMP_BWD: begin
                if (fill == 0) begin
                    step_beats.push_back(make_beat('0, STATUS_EMPTY, 1'b1));
                end else begin
                    idx = (kind == KIND_DUMP_FWD) ? head_idx : ring_prev(tail_idx);
                    for (int unsigned n = 0; n < fill; n++) begin
                        step_beats.push_back(make_beat(ring_model[idx], STATUS_OK,
                                                       (n + 1 == fill)));
                        idx = (kind == KIND_DUMP_FWD) ? ring_next(idx) : ring_prev(idx);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [VALUE_W-1:0] value,
                           input bit typed, input beat_t typed_beat);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        do @(posedge i_clk); while (o_busy);
        run_queue_op(kind, value);
        if (typed) begin
            expected_beats.push_back(typed_beat);
        end else begin
            foreach (step_beats[k]) expected_beats.push_back(step_beats[k]);
        end
        @(negedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random_phase(input int pct);
        int    ops_sent;
        int    roll;
        bit    filling;
        beat_t none_beat;
        ops_sent  = 0;
        filling   = 1'b1;
        none_beat = make_beat('0, STATUS_OK, 1'b0);
        idle_pct  = pct;
        while (ops_sent < RANDOM_OPS) begin
            if (filling && fill == BDQ_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
            if (!filling && fill == 0 && $urandom_range(3) == 0) filling = 1'b1;
            roll = $urandom_range(99);
            if (roll < 2) begin
                send_op((roll == 0) ? KIND_UNUSED_6 : KIND_UNUSED_7, $urandom, 1'b0,
                        none_beat);
                continue;
            end
            if (roll < 12) begin
                send_op($urandom_range(1) ? KIND_DUMP_FWD : KIND_DUMP_BWD, $urandom, 1'b0,
                        none_beat);
            end else if ($urandom_range(99) < (filling ? 75 : 25)) begin
                send_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value(),
                        1'b0, none_beat);
            end else begin
                send_op($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK, $urandom, 1'b0,
                        none_beat);
            end
            ops_sent++;
        end
    endtask

    always @(posedge i_clk) begin
        beat_t exp_beat;
        if (i_rst_n && o_valid) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat value=%0d status=%0d last=%0b",
                         $time, o_item_value, o_status, o_last);
                error_count++;
            end else begin
                exp_beat = expected_beats.pop_front();
                if (o_item_value !== exp_beat.value) begin
                    $display("%0t: item_value expected %0d, actual %0d",
                             $time, exp_beat.value, o_item_value);
                    error_count++;
                end
                if (o_status !== exp_beat.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, exp_beat.status, o_status);
                    error_count++;
                end
                if (o_last !== exp_beat.last) begin
                    $display("%0t: last expected %0b, actual %0b",
                             $time, exp_beat.last, o_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("bounded_double_ended_queue_unit regression: fail");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind  = '0;
        i_value = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 6;
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_op(directed_rows[r].kind, directed_rows[r].value + k,
                        directed_rows[r].typed,
                        make_beat(directed_rows[r].exp_value, directed_rows[r].exp_status,
                                  1'b1));
            end
        end

        run_random_phase(6);
        run_random_phase(78);
        run_random_phase(0);
        i_start <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("bounded_double_ended_queue_unit regression: pass");
        end else begin
            $display("bounded_double_ended_queue_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bounded_double_ended_queue_unit.sv
sim/bounded_double_ended_queue_unit_tb.sv
